// ----- rtl/chip8_instruction_execute_assert.svh -----
// Assertion macros shared by the CHIP-8 core modules.
`ifndef CHIP8_INSTRUCTION_EXECUTE_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_ASSERT_SVH
// Implication checked on every clock, skipped during reset.
`define C8_ASSERT_IMP(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define C8_ASSERT_NXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- rtl/c8ie_pkg.sv -----
// Shared types and constants for the CHIP-8 core.
`default_nettype none
package c8ie_pkg;
  localparam int unsigned MemBytes   = 4096;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned AddrW      = 12;
  localparam int unsigned SpW        = $clog2(StackDepth + 1);
  localparam int unsigned SidxW      = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  localparam logic [1:0] OpWrite  = 2'd0;
  localparam logic [1:0] OpExec   = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StHalt  = 2'd1;
  localparam logic [1:0] StStack = 2'd2;

  // Config register byte addresses
  localparam logic [2:0] RegOrigQuirk = 3'd0;
  localparam logic [2:0] RegIncQuirk  = 3'd4;

  localparam logic [AddrW-1:0] PcReset  = 12'h200;
  localparam logic [7:0]       FontBase = 8'h50;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MEMRD, S_MEMRD2, S_FETCH0, S_FETCH1, S_FETCH2, S_EXEC,
    S_STKRD, S_BULK, S_BULKRD, S_DONE
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;         // zero one memory byte after reset
    logic latch_item;    // capture input item fields
    logic mem_wr_item;   // write item byte
    logic mem_rd_item;   // read at item address
    logic cap_rd;        // capture read data
    logic fetch_hi;      // address pc
    logic fetch_lo;      // address pc+1, capture high byte
    logic cap_lo;        // capture low byte
    logic exec;          // execute decoded instruction
    logic stk_rd;        // read stack at sp-1
    logic ret_done;      // finish return
    logic bulk_step;     // store/load one register
    logic bulk_cap;      // load captured byte into register
    logic bulk_end;      // finish bulk op
    logic done;          // emit result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic       clear_last;
    logic [1:0] op;
    logic       halted;
    logic       is_ret;
    logic       ret_ok;
    logic       is_store;
    logic       is_load;
    logic       bulk_last;
  } stat_t;
endpackage
`default_nettype wire

// ----- rtl/c8ie_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module c8ie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/c8ie_ctrl.sv -----
// Sequencer for the CHIP-8 core.
`default_nettype none
module c8ie_ctrl import c8ie_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire stat_t stat_i,
  output logic       busy_o,
  output cmd_t       cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != S_IDLE);
    unique case (state_q)
      // zero the memory once after reset
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: if (start_i) begin
        cmd_o.latch_item = 1'b1;
        state_d = S_FETCH0;
      end
      S_FETCH0: begin
        // dispatch on latched op
        unique case (stat_i.op)
          OpWrite: begin cmd_o.mem_wr_item = 1'b1; state_d = S_DONE; end
          OpRead:  begin cmd_o.mem_rd_item = 1'b1; state_d = S_MEMRD; end
          OpExec: begin
            if (stat_i.halted) state_d = S_DONE;
            else begin cmd_o.fetch_hi = 1'b1; state_d = S_FETCH1; end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_MEMRD:  state_d = S_MEMRD2;
      S_MEMRD2: begin cmd_o.cap_rd = 1'b1; state_d = S_DONE; end
      S_FETCH1: begin cmd_o.fetch_lo = 1'b1; state_d = S_FETCH2; end
      S_FETCH2: begin cmd_o.cap_lo = 1'b1; state_d = S_EXEC; end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.is_ret && stat_i.ret_ok) begin
          cmd_o.stk_rd = 1'b1; state_d = S_STKRD;
        end else if (stat_i.is_store || stat_i.is_load) state_d = S_BULK;
        else state_d = S_DONE;
      end
      S_STKRD: begin cmd_o.ret_done = 1'b1; state_d = S_DONE; end
      S_BULK: begin
        cmd_o.bulk_step = 1'b1;
        state_d = stat_i.is_load ? S_BULKRD : S_BULK;
        if (!stat_i.is_load && stat_i.bulk_last) begin
          cmd_o.bulk_end = 1'b1; state_d = S_DONE;
        end
      end
      S_BULKRD: begin
        cmd_o.bulk_cap = 1'b1;
        if (stat_i.bulk_last) begin cmd_o.bulk_end = 1'b1; state_d = S_DONE; end
        else state_d = S_BULK;
      end
      S_DONE: begin cmd_o.done = 1'b1; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  `include "chip8_instruction_execute_assert.svh"
  `C8_ASSERT_NXT(a_done_idle, clk_i, rst_ni, state_q == S_DONE, state_q == S_IDLE)
  `C8_ASSERT_IMP(a_start_busy, clk_i, rst_ni, cmd_o.latch_item, state_q == S_IDLE)
  `C8_ASSERT_IMP(a_one_mem, clk_i, rst_ni, 1'b1,
    $onehot0({cmd_o.mem_wr_item, cmd_o.mem_rd_item, cmd_o.fetch_hi, cmd_o.fetch_lo,
              cmd_o.bulk_step}))
endmodule
`default_nettype wire

// ----- rtl/c8ie_dp.sv -----
// Datapath of the CHIP-8 core: memory, registers, stack and ALU.
`default_nettype none
module c8ie_dp import c8ie_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire logic [1:0]  op_i,
  input  wire logic [11:0] address_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [7:0]  random_byte_i,
  input  wire logic        oq_i,
  input  wire logic        iq_i,
  output stat_t            stat_o,
  output logic [1:0]       status_o,
  output logic [7:0]       read_data_o,
  output logic [11:0]      pc_o,
  output logic [15:0]      index_o,
  output logic [7:0]       delay_o,
  output logic [7:0]       sound_o
);
  logic [1:0]  op_q;
  logic [11:0] addr_q;
  logic [7:0]  wd_q, rnd_q, hi_q, lo_q, rd_q;
  logic [11:0] pc_q, pc_d;
  logic [15:0] idx_q, idx_d;
  logic [7:0]  dly_q, dly_d, snd_q, snd_d;
  logic [7:0]  v_q [16];
  logic [SpW-1:0] sp_q, sp_d;
  logic        halt_q, halt_d;
  logic [1:0]  st_q, st_d;
  logic [3:0]  bi_q;
  logic [AddrW-1:0] clr_q;
  logic [7:0]  mem_rdata;
  logic [11:0] stk_rdata;

  // decode from latched instruction
  logic [3:0] x, y, n, opc;
  logic [7:0] nn, vx, vy;
  logic [11:0] nnn, pc2;
  assign opc = hi_q[7:4];
  assign x = hi_q[3:0];
  assign y = lo_q[7:4];
  assign n = lo_q[3:0];
  assign nn = lo_q;
  assign nnn = {x, lo_q};
  assign vx = v_q[x];
  assign vy = v_q[y];
  assign pc2 = pc_q + 12'd2;
  logic is_ret, is_call, is_store, is_load;
  assign is_ret = (opc == 4'h0) && (nnn == 12'h0EE);
  assign is_call = (opc == 4'h2);
  assign is_store = (opc == 4'hF) && (nn == 8'h55);
  assign is_load  = (opc == 4'hF) && (nn == 8'h65);

  // memory port mux
  logic        mem_we;
  logic [11:0] mem_a;
  logic [7:0]  mem_wd;
  always_comb begin
    mem_we = 1'b0; mem_a = addr_q; mem_wd = wd_q;
    if (cmd_i.clear) begin
      mem_we = 1'b1; mem_a = clr_q; mem_wd = '0;
    end
    else if (cmd_i.mem_wr_item) mem_we = 1'b1;
    else if (cmd_i.mem_rd_item) mem_a = addr_q;
    else if (cmd_i.fetch_hi) mem_a = pc_q;
    else if (cmd_i.fetch_lo) mem_a = pc_q + 12'd1;
    else if (cmd_i.bulk_step) begin
      mem_a = idx_q[11:0] + {8'd0, bi_q};
      mem_wd = v_q[bi_q];
      mem_we = is_store;
    end
  end

  c8ie_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk_i, .we_i(mem_we), .addr_i(mem_a), .wdata_i(mem_wd), .rdata_o(mem_rdata));

  // stack: write at sp on call, read at sp-1 on return
  logic        stk_we;
  logic [SidxW-1:0] stk_a;
  assign stk_we = cmd_i.exec && is_call && (sp_q < SpW'(StackDepth));
  assign stk_a = cmd_i.stk_rd ? SidxW'(sp_q - SpW'(1)) : SidxW'(sp_q);
  c8ie_ram #(.Width(12), .Depth(StackDepth)) u_stk (
    .clk_i, .we_i(stk_we), .addr_i(stk_a), .wdata_i(pc_q), .rdata_o(stk_rdata));

  assign stat_o.clear_last = (clr_q == '1);
  assign stat_o.op = op_q;
  assign stat_o.halted = halt_q;
  assign stat_o.is_ret = is_ret;
  assign stat_o.ret_ok = (sp_q != '0);
  assign stat_o.is_store = is_store;
  assign stat_o.is_load = is_load;
  assign stat_o.bulk_last = (bi_q == x);

  // register file and machine state next value
  logic [7:0] v_d [16];
  logic [8:0] sum, dif, rdf;
  logic [7:0] sh;
  logic [16:0] isum;
  always_comb begin
    for (int i = 0; i < 16; i++) v_d[i] = v_q[i];
    pc_d = pc_q; idx_d = idx_q; dly_d = dly_q; snd_d = snd_q;
    sp_d = sp_q; halt_d = halt_q; st_d = st_q;
    sum = {1'b0, vx} + {1'b0, vy};
    dif = {1'b0, vx} - {1'b0, vy};
    rdf = {1'b0, vy} - {1'b0, vx};
    sh = oq_i ? vy : vx;
    isum = {1'b0, idx_q} + {9'd0, vx};
    if (cmd_i.latch_item) st_d = (op_i == OpExec && halt_q) ? StHalt : StOk;
    if (cmd_i.cap_lo) pc_d = pc2;
    if (cmd_i.exec) begin
      unique case (opc)
        4'h0: begin
          if (nnn == 12'h000) begin halt_d = 1'b1; st_d = StHalt; end
          else if (is_ret) begin
            if (sp_q == '0) st_d = StStack;
            else sp_d = sp_q - SpW'(1);
          end
        end
        4'h1: begin
          if (nnn == pc_q - 12'd2) begin halt_d = 1'b1; st_d = StHalt; end
          else pc_d = nnn;
        end
        4'h2: begin
          if (sp_q >= SpW'(StackDepth)) st_d = StStack;
          else begin sp_d = sp_q + SpW'(1); pc_d = nnn; end
        end
        4'h3: if (vx == nn) pc_d = pc2;
        4'h4: if (vx != nn) pc_d = pc2;
        4'h5: if (vx == vy) pc_d = pc2;
        4'h9: if (vx != vy) pc_d = pc2;
        4'h6: v_d[x] = nn;
        4'h7: v_d[x] = vx + nn;
        4'h8: begin
          unique case (n)
            4'h0: v_d[x] = vy;
            4'h1: v_d[x] = vx | vy;
            4'h2: v_d[x] = vx & vy;
            4'h3: v_d[x] = vx ^ vy;
            4'h4: begin v_d[x] = sum[7:0]; v_d[15] = {7'd0, sum[8]}; end
            4'h5: begin v_d[x] = dif[7:0]; v_d[15] = {7'd0, ~dif[8]}; end
            4'h7: begin v_d[x] = rdf[7:0]; v_d[15] = {7'd0, ~rdf[8]}; end
            4'h6: begin v_d[x] = {1'b0, sh[7:1]}; v_d[15] = {7'd0, sh[0]}; end
            4'hE: begin v_d[x] = {sh[6:0], 1'b0}; v_d[15] = {7'd0, sh[7]}; end
            default: ;
          endcase
        end
        4'hA: idx_d = {4'd0, nnn};
        4'hB: pc_d = nnn + {4'd0, (oq_i ? v_q[0] : vx)};
        4'hC: v_d[x] = rnd_q & nn;
        4'hF: begin
          unique case (nn)
            8'h07: v_d[x] = dly_q;
            8'h15: dly_d = vx;
            8'h18: snd_d = vx;
            8'h1E: begin
              if (isum[15:0] > 16'h0FFF) begin
                idx_d = {4'd0, isum[11:0]}; v_d[15] = 8'd1;
              end else idx_d = isum[15:0];
            end
            8'h29: idx_d = {8'd0, FontBase} + {10'd0, vx[3:0], 2'b00} + {12'd0, vx[3:0]};
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (cmd_i.ret_done) pc_d = stk_rdata;
    if (cmd_i.bulk_cap) v_d[bi_q] = mem_rdata;
    if (cmd_i.bulk_end && iq_i) idx_d = idx_q + {12'd0, x} + 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcReset; idx_q <= '0; dly_q <= '0; snd_q <= '0; sp_q <= '0;
      halt_q <= 1'b0; st_q <= StOk; op_q <= OpWrite; bi_q <= '0; clr_q <= '0;
      for (int i = 0; i < 16; i++) v_q[i] <= '0;
    end else begin
      pc_q <= pc_d; idx_q <= idx_d; dly_q <= dly_d; snd_q <= snd_d; sp_q <= sp_d;
      halt_q <= halt_d; st_q <= st_d;
      for (int i = 0; i < 16; i++) v_q[i] <= v_d[i];
      if (cmd_i.clear) clr_q <= clr_q + AddrW'(1);
      if (cmd_i.latch_item) op_q <= op_i;
      if (cmd_i.exec) bi_q <= '0;
      else if ((cmd_i.bulk_step && !is_load) || cmd_i.bulk_cap) bi_q <= bi_q + 4'd1;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      addr_q <= address_i; wd_q <= write_data_i; rnd_q <= random_byte_i; rd_q <= '0;
      hi_q <= '0; lo_q <= '0;
    end
    if (cmd_i.cap_rd) rd_q <= mem_rdata;
    if (cmd_i.fetch_lo) hi_q <= mem_rdata;
    if (cmd_i.cap_lo) lo_q <= mem_rdata;
  end

  assign status_o = st_q;
  assign read_data_o = rd_q;
  assign pc_o = pc_q;
  assign index_o = idx_q;
  assign delay_o = dly_q;
  assign sound_o = snd_q;

  `include "chip8_instruction_execute_assert.svh"
  `C8_ASSERT_IMP(a_sp_range, clk_i, rst_ni, 1'b1, sp_q <= SpW'(StackDepth))
  `C8_ASSERT_NXT(a_halt_sticky, clk_i, rst_ni, halt_q, halt_q)
  `C8_ASSERT_IMP(a_rd_zero, clk_i, rst_ni, cmd_i.done && op_q != OpRead, rd_q == 8'd0)
endmodule
`default_nettype wire

// ----- rtl/chip8_instruction_execute.sv -----
// Top level of the CHIP-8 core: config registers, sequencer and datapath.
// One item at a time: start is taken when busy is low, and the result appears
// on the result ports for one cycle with done_o high; the receiver cannot
// stall. After reset the core zeroes its 4096-byte memory, one byte a cycle,
// and busy stays high until that pass ends. An instruction is fetched a byte
// at a time through the single memory port (registered read), which also
// serves item reads and the FX55/FX65 bulk transfers; FX65 waits for each
// read byte before loading it. Busy drops in the cycle after done.
`default_nettype none
module chip8_instruction_execute import c8ie_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op_i,
  input  wire logic [11:0] address_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [7:0]  random_byte_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [7:0]       read_data_o,
  output logic [11:0]      program_counter_o,
  output logic [15:0]      index_value_o,
  output logic [7:0]       delay_value_o,
  output logic [7:0]       sound_value_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic oq_q, iq_q;
  cmd_t cmd;
  stat_t stat;

  // quirk registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_q <= 1'b1; iq_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr == RegOrigQuirk) oq_q <= pwdata[0];
      else if (paddr == RegIncQuirk) iq_q <= pwdata[0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == RegOrigQuirk) prdata[0] = oq_q;
    else if (paddr == RegIncQuirk) prdata[0] = iq_q;
  end

  c8ie_ctrl u_ctrl (.clk_i, .rst_ni, .start_i(start), .stat_i(stat), .busy_o(busy),
    .cmd_o(cmd));

  c8ie_dp u_dp (.clk_i, .rst_ni, .cmd_i(cmd), .op_i, .address_i, .write_data_i,
    .random_byte_i, .oq_i(oq_q), .iq_i(iq_q), .stat_o(stat), .status_o,
    .read_data_o, .pc_o(program_counter_o), .index_o(index_value_o),
    .delay_o(delay_value_o), .sound_o(sound_value_o));

  assign done_o = cmd.done;
endmodule
`default_nettype wire

// ----- tb/chip8_instruction_execute_checker.sv -----
// Checker for the CHIP-8 core: tracks accepted items and compares each result.
module chip8_instruction_execute_checker import c8ie_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  op_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  random_byte_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  read_data_i,
  input  logic [11:0] program_counter_i,
  input  logic [15:0] index_value_i,
  input  logic [7:0]  delay_value_i,
  input  logic [7:0]  sound_value_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o
);
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  rdata;
    logic [11:0] pc;
    logic [15:0] idx;
    logic [7:0]  dly;
    logic [7:0]  snd;
  } core_view_t;

  // Shadow core state
  logic [7:0]  mem [MemBytes];
  logic [7:0]  v [16];
  logic [11:0] pc;
  logic [15:0] idx;
  logic [11:0] stk [StackDepth];
  int          sp;
  logic [7:0]  dly, snd;
  logic        halted;
  logic        q_orig, q_inc;

  core_view_t  expected_views[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_views.size();

  // Eight-bit ALU group, flag written last
  function automatic void do_alu(input int x, input int y, input int n);
    logic [8:0] s;
    logic [7:0] src;
    case (n)
      0: v[x] = v[y];
      1: v[x] = v[x] | v[y];
      2: v[x] = v[x] & v[y];
      3: v[x] = v[x] ^ v[y];
      4: begin
        s = v[x] + v[y]; v[x] = s[7:0]; v[15] = {7'd0, s[8]};
      end
      5: begin
        s = {1'b0, v[x]} - v[y]; v[x] = s[7:0]; v[15] = {7'd0, ~s[8]};
      end
      7: begin
        s = {1'b0, v[y]} - v[x]; v[x] = s[7:0]; v[15] = {7'd0, ~s[8]};
      end
      6: begin
        src = q_orig ? v[y] : v[x]; v[x] = src >> 1; v[15] = {7'd0, src[0]};
      end
      14: begin
        src = q_orig ? v[y] : v[x]; v[x] = src << 1; v[15] = {7'd0, src[7]};
      end
      default: ;
    endcase
  endfunction

  // Fetch and execute one instruction; returns status
  function automatic logic [1:0] run_instr(input logic [7:0] rnd);
    logic [11:0] at, nnn;
    logic [15:0] ins, s;
    logic [7:0]  nn;
    int          x, y;
    at  = pc;
    ins = {mem[at], mem[at + 12'd1]};
    x = ins[11:8]; y = ins[7:4]; nn = ins[7:0]; nnn = ins[11:0];
    pc = at + 12'd2;
    case (ins[15:12])
      4'h0: begin
        if (nnn == 12'h000) begin
          halted = 1'b1; return StHalt;
        end
        if (nnn == 12'h0EE) begin
          if (sp == 0) return StStack;
          sp--; pc = stk[sp];
        end
      end
      4'h1: begin
        if (nnn == at) begin
          halted = 1'b1; return StHalt;
        end
        pc = nnn;
      end
      4'h2: begin
        if (sp >= StackDepth) return StStack;
        stk[sp] = pc; sp++; pc = nnn;
      end
      4'h3: if (v[x] == nn) pc = pc + 12'd2;
      4'h4: if (v[x] != nn) pc = pc + 12'd2;
      4'h5: if (v[x] == v[y]) pc = pc + 12'd2;
      4'h9: if (v[x] != v[y]) pc = pc + 12'd2;
      4'h6: v[x] = nn;
      4'h7: v[x] = v[x] + nn;
      4'h8: do_alu(x, y, ins[3:0]);
      4'hA: idx = {4'd0, nnn};
      4'hB: pc = nnn + (q_orig ? v[0] : v[x]);
      4'hC: v[x] = rnd & nn;
      4'hF: begin
        case (nn)
          8'h07: v[x] = dly;
          8'h15: dly = v[x];
          8'h18: snd = v[x];
          8'h1E: begin
            s = idx + v[x];
            if (s > 16'h0FFF) begin
              s = s & 16'h0FFF; v[15] = 8'd1;
            end
            idx = s;
          end
          8'h29: idx = FontBase + v[x][3:0] * 16'd5;
          8'h55: begin
            for (int i = 0; i <= x; i++) mem[12'(idx + i)] = v[i];
            if (q_inc) idx = idx + x + 1;
          end
          8'h65: begin
            for (int i = 0; i <= x; i++) v[i] = mem[12'(idx + i)];
            if (q_inc) idx = idx + x + 1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return StOk;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    core_view_t e, got;
    if (!rst_ni) begin
      foreach (mem[i]) mem[i] = 8'd0;
      foreach (v[i]) v[i] = 8'd0;
      foreach (stk[i]) stk[i] = 12'd0;
      pc = PcReset; idx = 16'd0; sp = 0; dly = 8'd0; snd = 8'd0;
      halted = 1'b0; q_orig = 1'b1; q_inc = 1'b0;
      expected_views.delete();
      fails = 0;
    end else begin
      // Compare result against oldest expectation
      if (done_i) begin
        got = '{status_i, read_data_i, program_counter_i, index_value_i,
                delay_value_i, sound_value_i};
        if (expected_views.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %h", got);
        end else begin
          e = expected_views.pop_front();
          if (got !== e) begin
            fails++;
            if (fails <= 10)
              $display({"mismatch: exp st=%0d rd=%h pc=%h i=%h d=%h s=%h",
                        " | got st=%0d rd=%h pc=%h i=%h d=%h s=%h"},
                       e.status, e.rdata, e.pc, e.idx, e.dly, e.snd,
                       got.status, got.rdata, got.pc, got.idx, got.dly, got.snd);
          end
        end
      end
      // Register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == RegOrigQuirk) q_orig = pwdata_i[0];
        if (paddr_i == RegIncQuirk) q_inc  = pwdata_i[0];
      end
      // Predict accepted item
      if (start_i && !busy_i) begin
        e.status = StOk; e.rdata = 8'd0;
        if (op_i == OpWrite) mem[address_i] = write_data_i;
        else if (op_i == OpRead) e.rdata = mem[address_i];
        else if (op_i == OpExec) e.status = halted ? StHalt : run_instr(random_byte_i);
        e.pc = pc; e.idx = idx; e.dly = dly; e.snd = snd;
        expected_views.push_back(e);
      end
    end
  end
endmodule

// ----- tb/tb_chip8_instruction_execute.sv -----
// Testbench top for the CHIP-8 core: stimulus, register setup and verdict.
module tb_chip8_instruction_execute;
  import c8ie_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op_i = OpWrite;
  logic [11:0] address_i = '0;
  logic [7:0]  write_data_i = '0;
  logic [7:0]  random_byte_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [7:0]  read_data_o, delay_value_o, sound_value_o;
  logic [11:0] program_counter_o;
  logic [15:0] index_value_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          allow_gaps = 1'b1;
  // Program counter seen on the last result
  logic [11:0] i_pc_shadow = PcReset;

  // Covers the memory clearing pass after reset with wide margin
  localparam int WatchdogLimit = 20000;

  always #6 clk_i = ~clk_i;

  chip8_instruction_execute i_dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .address_i, .write_data_i,
    .random_byte_i, .done_o, .status_o, .read_data_o, .program_counter_o,
    .index_value_o, .delay_value_o, .sound_value_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  chip8_instruction_execute_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .op_i, .address_i,
    .write_data_i, .random_byte_i, .done_i(done_o), .status_i(status_o),
    .read_data_i(read_data_o), .program_counter_i(program_counter_o),
    .index_value_i(index_value_o), .delay_value_i(delay_value_o),
    .sound_value_i(sound_value_o), .psel_i(psel), .penable_i(penable),
    .pwrite_i(pwrite), .paddr_i(paddr), .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog on cycles with nothing accepted
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("chip8_instruction_execute test failed");
      $finish;
    end
  end

  // Send one item, with an optional random gap before it
  task automatic send_item(input logic [1:0] op, input logic [11:0] addr,
                           input logic [7:0] wd, input logic [7:0] rnd);
    @(negedge clk_i);
    if (allow_gaps && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    op_i <= op; address_i <= addr; write_data_i <= wd; random_byte_i <= rnd;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic write_mem(input logic [11:0] addr, input logic [7:0] b);
    send_item(OpWrite, addr, b, 8'd0);
  endtask

  task automatic write_instr(input logic [11:0] addr, input logic [15:0] ins);
    write_mem(addr, ins[15:8]);
    write_mem(addr + 12'd1, ins[7:0]);
  endtask

  task automatic exec_instr(input logic [7:0] rnd);
    send_item(OpExec, i_pc_shadow, 8'd0, rnd);
  endtask

  // Quiet, then write one quirk register
  task automatic set_quirk(input logic [2:0] addr, input logic val);
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
    pwdata <= {31'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  always @(posedge clk_i) if (done_o) i_pc_shadow <= program_counter_o;

  // Pick a random instruction, mostly well-formed with bounded targets
  function automatic logic [15:0] rand_instr();
    logic [3:0] x, y;
    logic [7:0] nn;
    logic [7:0] fsel [9] = '{8'h07, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h55, 8'h65,
                             8'h33, 8'h0A};
    logic [3:0] asel [10] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
                              4'hE, 4'h9};
    x  = 4'($urandom); y = 4'($urandom); nn = 8'($urandom);
    case ($urandom_range(0, 15))
      0: return ($urandom_range(0, 1)) ? 16'h00EE : 16'h00E0;
      1: return {4'h2, 12'($urandom_range(12'h300, 12'h3FE))};
      2: return {4'h3, x, nn};
      3: return {4'h4, x, nn};
      4: return {4'h5, x, y, 4'h0};
      5: return {4'h9, x, y, 4'h0};
      6: return {4'h6, x, nn};
      7: return {4'h7, x, nn};
      8, 9: return {4'h8, x, y, asel[$urandom_range(0, 9)]};
      10: return {4'hA, 12'($urandom)};
      11: return {4'hC, x, nn};
      12, 13: return {4'hF, x, fsel[$urandom_range(0, 8)]};
      14: return {4'hB, 12'($urandom_range(12'h300, 12'h3F0))};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int items;
    logic [15:0] ins;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: memory extremes, read back, unused op
    write_mem(12'h000, 8'hFF);
    write_mem(12'hFFF, 8'hAA);
    send_item(OpRead, 12'hFFF, 8'h00, 8'h00);
    send_item(OpRead, 12'h000, 8'h00, 8'h00);
    send_item(OpUnused, 12'hFFF, 8'hFF, 8'hFF);
    // Program: V0=FF, V1=01, add, sub, shift, call, return, empty-stack return, I add, random, self-jump
    write_instr(12'h200, 16'h60FF);
    write_instr(12'h202, 16'h6101);
    write_instr(12'h204, 16'h8F14);
    write_instr(12'h206, 16'h8015);
    write_instr(12'h208, 16'h801E);
    write_instr(12'h20A, 16'h2300);
    write_instr(12'h300, 16'h00EE);
    write_instr(12'h20C, 16'h00EE);
    write_instr(12'h20E, 16'hAFFF);
    write_instr(12'h210, 16'hF01E);
    write_instr(12'h212, 16'hCFA5);
    write_instr(12'h214, 16'h1214);
    repeat (13) exec_instr(8'($urandom));
    send_item(OpRead, 12'h300, 8'h00, 8'h00);

    // Random phases over quirk settings
    for (int phase = 0; phase < 4; phase++) begin
      set_quirk(RegOrigQuirk, phase[0]);
      set_quirk(RegIncQuirk, phase[1]);
      allow_gaps = (phase != 3);
      items = 0;
      while (items < 100) begin
        // Mostly plant a random instruction at the current PC and execute it; sometimes read a random address
        if ($urandom_range(0, 9) == 0) begin
          send_item(OpRead, 12'($urandom), 8'h00, 8'h00);
          items++;
        end else begin
          ins = rand_instr();
          write_instr(i_pc_shadow, ins);
          exec_instr(8'($urandom));
          items += 3;
        end
      end
      // Halt via 0000 to exercise the halted path, then one more exec and a memory write
      write_instr(i_pc_shadow, 16'h0000);
      exec_instr(8'h00);
      exec_instr(8'h00);
      write_mem(12'h123, 8'h5A);
    end

    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0) $display("chip8_instruction_execute test passed");
    else $display("chip8_instruction_execute test failed");
    $finish;
  end
endmodule
